>>> rtl/panel_monitor_controller_core_defines.svh
// Assertion macros used by the checker file.
`ifndef PANEL_MONITOR_CONTROLLER_CORE_DEFINES_SVH
`define PANEL_MONITOR_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pmc_pkg.sv
`timescale 1ns / 1ps

package pmc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_WINDOW_DEPTH  = 8;
    localparam int DEF_BUMP_INTERVAL = 50;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int RAW_W      = 16;
    localparam int BTN_W      = 3;
    localparam int JOY_W      = 5;
    localparam int DISP_W     = 8;
    localparam int AMP_W      = 10;
    localparam int LEVEL_W    = 2;
    localparam int TOTAL_W    = 32;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 96;

    // Constants
    localparam logic [SAMPLE_W-1:0] SAMPLE_CEIL = 12'd4095;
    localparam logic [AMP_W-1:0]    AMP_FULL    = 10'd1023;

    // Button and joystick bit positions
    localparam int BTN_RUN    = 0;
    localparam int BTN_LEVEL  = 1;
    localparam int BTN_RESET  = 2;
    localparam int JOY_SELECT = 0;
    localparam int JOY_DOWN   = 2;
    localparam int JOY_UP     = 3;

    // Phase codes
    localparam logic [LEVEL_W-1:0] LEVEL_0 = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1 = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIN,
        ST_DIV,
        ST_OUT
    } t_state;

    // Phase advance, modulo three
    function automatic logic [LEVEL_W-1:0] level_step(input logic [LEVEL_W-1:0] lvl);
        logic [LEVEL_W-1:0] res;
        case (lvl)
            LEVEL_0: res = LEVEL_1;
            LEVEL_1: res = LEVEL_2;
            default: res = LEVEL_0;
        endcase
        return res;
    endfunction

    // level * 85
    function automatic logic [DISP_W-1:0] level_display(input logic [LEVEL_W-1:0] lvl);
        logic [DISP_W-1:0] res;
        case (lvl)
            LEVEL_0: res = 8'd0;
            LEVEL_1: res = 8'd85;
            LEVEL_2: res = 8'd170;
            default: res = 8'd0;
        endcase
        return res;
    endfunction

    // (3 - level) * 341
    function automatic logic [AMP_W-1:0] level_amplitude(input logic [LEVEL_W-1:0] lvl);
        logic [AMP_W-1:0] res;
        case (lvl)
            LEVEL_0: res = AMP_FULL;
            LEVEL_1: res = 10'd682;
            LEVEL_2: res = 10'd341;
            default: res = AMP_FULL;
        endcase
        return res;
    endfunction

endpackage

>>> rtl/panel_monitor_controller_core.sv
`timescale 1ns / 1ps

// Front-panel monitor controller, one transaction per control tick.
// Input stream (s_axis): buttons, joystick lines and a raw sample in tdata,
// the sample-valid flag in tuser. Output stream (m_axis): display, DAC
// amplitude, run flag, phase, window mean, min, max and sample count.
// Each input transaction gives exactly one output transaction.
// A tick without a sample (or with a reset press) goes from acceptance
// through ST_WIN and ST_OUT to the output register; a tick with a sample
// also runs the window mean divide in ST_DIV between those two states.
// The divide unit retires two quotient bits per cycle. s_axis_tready is
// high only while the sequencer is idle, so a new tick is taken only once
// the previous one has left the sequencer for the output register.
// The output register holds a finished result while m_axis_tready is low;
// the next tick is still accepted and processed, and its result waits for
// the register to free up. Reset (i_rst_n low, synchronous) clears all
// state: running, phase 0, display 0, amplitude 1023, min 4095, max 0,
// empty window; no clearing pass is needed since the fill count masks the
// window memory.
module panel_monitor_controller_core
    import pmc_pkg::*;
#(
    parameter int WINDOW_DEPTH  = DEF_WINDOW_DEPTH,
    parameter int BUMP_INTERVAL = DEF_BUMP_INTERVAL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] buttons, [7:3] joystick, [23:8] sample_in
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] sample_valid
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] display, [17:8] amplitude, [18] run_flag, [20:19] level,
    // [32:21] window_mean, [44:33] sample_min, [56:45] sample_max,
    // [88:57] sample_total, [95:89] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = $clog2(WINDOW_DEPTH * 4095 + 1);
    localparam int PH_W   = $clog2(BUMP_INTERVAL);
    localparam int PAD_W  = OUT_DATA_W - TOTAL_W - 3 * SAMPLE_W
                            - LEVEL_W - 1 - AMP_W - DISP_W;

    // Input fields
    logic [BTN_W-1:0]    w_btn;
    logic [JOY_W-1:0]    w_joy;
    logic [RAW_W-1:0]    w_raw;
    logic                w_valid;

    assign w_btn   = s_axis_tdata[2:0];
    assign w_joy   = s_axis_tdata[7:3];
    assign w_raw   = s_axis_tdata[23:8];
    assign w_valid = s_axis_tuser[0];

    // State
    t_state              r_state, n_state;
    logic [BTN_W-1:0]    r_last_btn;
    logic [JOY_W-1:0]    r_last_joy;
    logic [PH_W-1:0]     r_phase;
    logic                r_run;
    logic [LEVEL_W-1:0]  r_level;
    logic [DISP_W-1:0]   r_display;
    logic [AMP_W-1:0]    r_amp;
    logic [TOTAL_W-1:0]  r_total;
    logic [SAMPLE_W-1:0] r_min;
    logic [SAMPLE_W-1:0] r_max;
    logic [PTR_W-1:0]    r_ptr;
    logic [FILL_W-1:0]   r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_mean;
    logic                r_take;
    logic [SAMPLE_W-1:0] r_s;
    logic [SAMPLE_W-1:0] r_old;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [SAMPLE_W-1:0] r_win_mem [WINDOW_DEPTH];

    // Next values for an accepted tick
    logic [BTN_W-1:0]    n_press;
    logic [JOY_W-1:0]    n_edges;
    logic [SAMPLE_W-1:0] n_s;
    logic [PH_W-1:0]     n_phase;
    logic                n_run;
    logic [LEVEL_W-1:0]  n_level;
    logic [DISP_W-1:0]   n_display;
    logic [SAMPLE_W-1:0] n_min;
    logic [SAMPLE_W-1:0] n_max;
    logic [TOTAL_W-1:0]  n_total;

    // Window update values
    logic [SAMPLE_W-1:0] w_evict;
    logic [SUM_W-1:0]    n_sum;
    logic [PTR_W-1:0]    n_ptr;
    logic [FILL_W-1:0]   n_fill;

    // Sequencer controls
    logic                w_accept;
    logic                w_win;
    logic                w_div_done;
    logic                w_load;

    // Divider
    logic                w_div_busy;
    logic [SUM_W-1:0]    w_quot;

    // Tick logic: edges, buttons, joystick, display chain, statistics
    always_comb begin
        n_press = w_btn & ~r_last_btn;
        n_edges = w_joy & ~r_last_joy;
        n_s     = (w_raw > RAW_W'(SAMPLE_CEIL)) ? SAMPLE_CEIL : w_raw[SAMPLE_W-1:0];
        n_phase = (r_phase == PH_W'(BUMP_INTERVAL - 1)) ? '0 : r_phase + 1'b1;
        n_run   = r_run ^ n_press[BTN_RUN];

        n_level = r_level;
        if (n_press[BTN_LEVEL]) begin
            n_level = level_step(n_level);
        end
        if (n_edges[JOY_SELECT]) begin
            n_level = level_step(n_level);
        end

        n_display = r_display;
        if (n_edges[JOY_UP]) begin
            n_display = n_display + 1'b1;
        end
        if (n_edges[JOY_DOWN]) begin
            n_display = n_display - 1'b1;
        end
        if (w_valid && n_run) begin
            n_display = n_s[SAMPLE_W-1:SAMPLE_W-DISP_W];
        end
        if (n_press[BTN_LEVEL]) begin
            n_display = level_display(n_level);
        end
        if (n_run && (n_phase == '0)) begin
            n_display = n_display + 1'b1;
        end

        n_min   = r_min;
        n_max   = r_max;
        n_total = r_total;
        if (w_valid) begin
            n_total = r_total + 1'b1;
            if (n_s < r_min) begin
                n_min = n_s;
            end
            if (n_s > r_max) begin
                n_max = n_s;
            end
        end
    end

    // Window update: the entry being replaced counts only once the window is full
    always_comb begin
        w_evict = (r_fill == FILL_W'(WINDOW_DEPTH)) ? r_old : '0;
        n_sum   = r_sum - SUM_W'(w_evict) + SUM_W'(r_s);
        n_ptr   = (r_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
        n_fill  = (r_fill == FILL_W'(WINDOW_DEPTH)) ? r_fill : r_fill + 1'b1;
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and controls
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_accept      = 1'b0;
        w_win         = 1'b0;
        w_div_done    = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    w_accept = 1'b1;
                    n_state  = ST_WIN;
                end
            end
            ST_WIN: begin
                if (r_take) begin
                    w_win   = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (!w_div_busy) begin
                    w_div_done = 1'b1;
                    n_state    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_btn <= '0;
            r_last_joy <= '0;
            r_phase    <= '0;
            r_run      <= 1'b1;
            r_level    <= LEVEL_0;
            r_display  <= '0;
            r_amp      <= AMP_FULL;
            r_total    <= '0;
            r_min      <= SAMPLE_CEIL;
            r_max      <= '0;
            r_ptr      <= '0;
            r_fill     <= '0;
            r_sum      <= '0;
            r_mean     <= '0;
        end else begin
            if (w_accept) begin
                r_last_btn <= w_btn;
                r_last_joy <= w_joy;
                if (n_press[BTN_RESET]) begin
                    r_phase   <= '0;
                    r_run     <= 1'b1;
                    r_level   <= LEVEL_0;
                    r_display <= '0;
                    r_amp     <= AMP_FULL;
                    r_total   <= '0;
                    r_min     <= SAMPLE_CEIL;
                    r_max     <= '0;
                    r_ptr     <= '0;
                    r_fill    <= '0;
                    r_sum     <= '0;
                    r_mean    <= '0;
                end else begin
                    r_phase   <= n_phase;
                    r_run     <= n_run;
                    r_level   <= n_level;
                    r_display <= n_display;
                    r_amp     <= level_amplitude(n_level);
                    r_total   <= n_total;
                    r_min     <= n_min;
                    r_max     <= n_max;
                end
            end
            if (w_win) begin
                r_sum  <= n_sum;
                r_ptr  <= n_ptr;
                r_fill <= n_fill;
            end
            if (w_div_done) begin
                r_mean <= w_quot[SAMPLE_W-1:0];
            end
        end
    end

    // Sample held for the window step
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_take <= w_valid && !n_press[BTN_RESET];
            r_s    <= n_s;
        end
    end

    // Window memory: one write, one registered read at the pointer
    always_ff @(posedge i_clk) begin
        if (w_win) begin
            r_win_mem[r_ptr] <= r_s;
        end
        r_old <= r_win_mem[r_ptr];
    end

    // Mean = sum / fill
    pmc_div #(
        .NUM_W (SUM_W),
        .DEN_W (FILL_W)
    ) u_pmc_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_win),
        .i_num   (n_sum),
        .i_den   (n_fill),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {PAD_W'(0), r_total, r_max, r_min, r_mean,
                           r_level, r_run, r_amp, r_display};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/pmc_div.sv
`timescale 1ns / 1ps

// Restoring divider, two quotient bits per cycle
module pmc_div
    import pmc_pkg::*;
#(
    parameter int NUM_W = 15,
    parameter int DEN_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int PAD_W = NUM_W + (NUM_W % 2);
    localparam int ITER  = PAD_W / 2;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [PAD_W-1:0] r_q;
    logic [DEN_W-1:0] n_rem;
    logic [PAD_W-1:0] n_q;

    // Two compare-subtract steps
    always_comb begin
        logic [DEN_W:0] t;
        n_rem = r_rem;
        n_q   = r_q;
        t     = '0;
        for (int k = 0; k < 2; k++) begin
            t   = {n_rem, n_q[PAD_W-1]};
            n_q = {n_q[PAD_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t      = t - {1'b0, r_den};
                n_q[0] = 1'b1;
            end
            n_rem = t[DEN_W-1:0];
        end
    end

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(ITER);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= PAD_W'(i_num);
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q[NUM_W-1:0];

endmodule

>>> rtl/pmc_checker.sv
`timescale 1ns / 1ps
`include "panel_monitor_controller_core_defines.svh"

// Port-level checks on the monitor controller
module pmc_checker
    import pmc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Stalled result holds
    `PMC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    // One tick at a time: not ready right after a transaction
    `PMC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after input transaction")

    // Amplitude follows the phase, phase never 3
    `PMC_ASSERT_IMP(a_amp_level, m_axis_tvalid, (m_axis_tdata[20:19] != 2'd3) && (m_axis_tdata[17:8] == level_amplitude(m_axis_tdata[20:19])), "amplitude does not match phase")

    // Once samples exist, min <= mean <= max
    `PMC_ASSERT_IMP(a_stats_order, m_axis_tvalid && (m_axis_tdata[88:57] != '0), (m_axis_tdata[44:33] <= m_axis_tdata[32:21]) && (m_axis_tdata[32:21] <= m_axis_tdata[56:45]), "min, mean, max out of order")

endmodule

bind panel_monitor_controller_core pmc_checker u_pmc_checker (.*);

>>> verif/panel_monitor_controller_core_tb.sv
`timescale 1ns / 1ps

module panel_monitor_controller_core_tb;

    import pmc_pkg::*;

    localparam int WIN_DEPTH   = DEF_WINDOW_DEPTH;
    localparam int BUMP_TICKS  = DEF_BUMP_INTERVAL;
    localparam int LEVEL_COUNT = 3;
    localparam int LEVEL_STEP  = 85;
    localparam int AMP_STEP    = 341;
    localparam int MAX_GAP     = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    // One output transaction, field by field
    typedef struct {
        logic [DISP_W-1:0]   disp;
        logic [AMP_W-1:0]    amp;
        logic                run;
        logic [LEVEL_W-1:0]  lvl;
        logic [SAMPLE_W-1:0] mean;
        logic [SAMPLE_W-1:0] mn;
        logic [SAMPLE_W-1:0] mx;
        logic [TOTAL_W-1:0]  total;
    } panel_out_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [2:0] buttons, [7:3] joystick, [23:8] sample_in
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [0] sample_valid
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [7:0] display, [17:8] amplitude, [18] run_flag, [20:19] level,
    // [32:21] window_mean, [44:33] sample_min, [56:45] sample_max,
    // [88:57] sample_total, [95:89] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    panel_out_t expected_panel_out[$];
    int         mismatch_count;
    int         checked_count;
    int         cycle_count;
    bit         tx_idle_on;
    bit         rx_idle_on;
    int         rx_hold_cycles;

    // Panel state as the block should hold it
    logic [BTN_W-1:0]    prev_btn;
    logic [JOY_W-1:0]    prev_joy;
    int                  tick_cnt;
    logic                run_on;
    logic [LEVEL_W-1:0]  phase_lvl;
    logic [DISP_W-1:0]   disp_val;
    logic [AMP_W-1:0]    amp_val;
    logic [TOTAL_W-1:0]  smp_count;
    logic [SAMPLE_W-1:0] smp_min;
    logic [SAMPLE_W-1:0] smp_max;
    int                  win_mem [WIN_DEPTH];
    int                  win_ptr;
    int                  win_fill;
    int                  win_sum;
    logic [SAMPLE_W-1:0] win_mean;

    panel_monitor_controller_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic clear_panel_model();
        prev_btn  = '0;
        prev_joy  = '0;
        tick_cnt  = 0;
        run_on    = 1'b1;
        phase_lvl = LEVEL_0;
        disp_val  = '0;
        amp_val   = AMP_FULL;
        smp_count = '0;
        smp_min   = SAMPLE_CEIL;
        smp_max   = '0;
        foreach (win_mem[i]) win_mem[i] = 0;
        win_ptr   = 0;
        win_fill  = 0;
        win_sum   = 0;
        win_mean  = '0;
    endtask

    task automatic advance_phase();
        if (phase_lvl == LEVEL_2) begin
            phase_lvl = LEVEL_0;
        end else begin
            phase_lvl = phase_lvl + 1'b1;
        end
    endtask

    // Apply one accepted tick and queue the output it should produce
    task automatic advance_panel_model(input logic [BTN_W-1:0] btn,
                                       input logic [JOY_W-1:0] joy,
                                       input logic vld,
                                       input logic [RAW_W-1:0] raw);
        logic [BTN_W-1:0]    press;
        logic [JOY_W-1:0]    jedge;
        logic [SAMPLE_W-1:0] smp;
        panel_out_t          res;
        press = btn & ~prev_btn;
        jedge = joy & ~prev_joy;
        smp   = (raw > SAMPLE_CEIL) ? SAMPLE_CEIL : raw[SAMPLE_W-1:0];
        prev_btn = btn;
        prev_joy = joy;
        tick_cnt = (tick_cnt + 1) % BUMP_TICKS;
        if (press[BTN_RESET]) begin
            clear_panel_model();
            prev_btn = btn;
            prev_joy = joy;
        end else begin
            // sample statistics and window
            if (vld) begin
                smp_count = smp_count + 1'b1;
                if (smp < smp_min) smp_min = smp;
                if (smp > smp_max) smp_max = smp;
                win_sum = win_sum - win_mem[win_ptr] + int'(smp);
                win_mem[win_ptr] = smp;
                win_ptr = (win_ptr + 1) % WIN_DEPTH;
                if (win_fill < WIN_DEPTH) win_fill++;
                win_mean = win_sum / win_fill;
            end
            if (press[BTN_RUN]) run_on = ~run_on;
            if (press[BTN_LEVEL]) advance_phase();
            if (jedge[JOY_UP]) disp_val = disp_val + 1'b1;
            if (jedge[JOY_DOWN]) disp_val = disp_val - 1'b1;
            if (jedge[JOY_SELECT]) advance_phase();
            if (vld && run_on) disp_val = smp >> 4;
            if (press[BTN_LEVEL]) disp_val = phase_lvl * LEVEL_STEP;
            // periodic bump while running
            if (run_on && tick_cnt == 0) disp_val = disp_val + 1'b1;
            amp_val = (LEVEL_COUNT - phase_lvl) * AMP_STEP;
        end
        res.disp  = disp_val;
        res.amp   = amp_val;
        res.run   = run_on;
        res.lvl   = phase_lvl;
        res.mean  = win_mean;
        res.mn    = smp_min;
        res.mx    = smp_max;
        res.total = smp_count;
        expected_panel_out.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] output %0d %s: got %0d, expected %0d",
                 $realtime, checked_count, what, got, want);
        mismatch_count++;
    endtask

    // Output checker
    always @(posedge i_clk) begin
        panel_out_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_panel_out.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = expected_panel_out.pop_front();
                if (m_axis_tdata[7:0] !== want.disp)
                    report_mismatch("display", m_axis_tdata[7:0], want.disp);
                if (m_axis_tdata[17:8] !== want.amp)
                    report_mismatch("amplitude", m_axis_tdata[17:8], want.amp);
                if (m_axis_tdata[18] !== want.run)
                    report_mismatch("run_flag", m_axis_tdata[18], want.run);
                if (m_axis_tdata[20:19] !== want.lvl)
                    report_mismatch("level", m_axis_tdata[20:19], want.lvl);
                if (m_axis_tdata[32:21] !== want.mean)
                    report_mismatch("window_mean", m_axis_tdata[32:21], want.mean);
                if (m_axis_tdata[44:33] !== want.mn)
                    report_mismatch("sample_min", m_axis_tdata[44:33], want.mn);
                if (m_axis_tdata[56:45] !== want.mx)
                    report_mismatch("sample_max", m_axis_tdata[56:45], want.mx);
                if (m_axis_tdata[88:57] !== want.total)
                    report_mismatch("sample_total", m_axis_tdata[88:57], want.total);
                if (m_axis_tdata[95:89] !== 7'd0)
                    report_mismatch("pad bits", m_axis_tdata[95:89], 0);
            end
            checked_count++;
        end
    end

    // Output receiver: random stalls, plus a long hold when requested
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Offer one tick and wait for its transaction
    task automatic send_tick(input logic [BTN_W-1:0] btn, input logic [JOY_W-1:0] joy,
                             input logic vld, input logic [RAW_W-1:0] raw);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw, joy, btn};
        s_axis_tuser  <= vld;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_panel_model(btn, joy, vld, raw);
    endtask

    task automatic test_idle_ticks();
        send_tick(3'b000, 5'b00000, 1'b0, 16'h0000);
        send_tick(3'b000, 5'b00000, 1'b0, 16'hFFFF);
    endtask

    // Extremes and saturation, then samples while stopped
    task automatic test_sample_extremes();
        send_tick(3'b000, 5'b00000, 1'b1, 16'd0);
        send_tick(3'b000, 5'b00000, 1'b1, 16'd4095);
        send_tick(3'b000, 5'b00000, 1'b1, 16'd65535);
        send_tick(3'b000, 5'b00000, 1'b1, 16'd4096);
        send_tick(3'b001, 5'b00000, 1'b1, 16'd100);
        send_tick(3'b000, 5'b00000, 1'b1, 16'h8000);
        send_tick(3'b001, 5'b00000, 1'b1, 16'd2000);
    endtask

    // Level button, joystick edges, combined up/down, ignored lines
    task automatic test_panel_controls();
        send_tick(3'b010, 5'b00000, 1'b1, 16'd3000);
        send_tick(3'b000, 5'b00000, 1'b0, 16'd0);
        send_tick(3'b010, 5'b01000, 1'b0, 16'd0);
        send_tick(3'b000, 5'b00000, 1'b0, 16'd0);
        send_tick(3'b010, 5'b00000, 1'b0, 16'd0);
        send_tick(3'b000, 5'b01000, 1'b0, 16'd0);
        send_tick(3'b000, 5'b00100, 1'b0, 16'd0);
        send_tick(3'b000, 5'b01100, 1'b0, 16'd0);
        send_tick(3'b000, 5'b00001, 1'b0, 16'd0);
        send_tick(3'b000, 5'b10010, 1'b0, 16'd0);
        send_tick(3'b000, 5'b00000, 1'b0, 16'd0);
        send_tick(3'b000, 5'b00001, 1'b1, 16'd1234);
    endtask

    // Reset press beats everything in its tick; a joystick down edge follows
    task automatic test_reset_press();
        send_tick(3'b111, 5'b01101, 1'b1, 16'd4000);
        send_tick(3'b100, 5'b00000, 1'b1, 16'd50);
        send_tick(3'b000, 5'b00100, 1'b0, 16'd0);
    endtask

    // Hold the output off while the sender keeps offering
    task automatic test_backpressure();
        int i;
        tx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 25; i++) begin
            send_tick($urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 1),
                      $urandom_range(0, 65535));
        end
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_ticks(input int count);
        int                  i;
        logic [BTN_W-1:0]    btn;
        logic [JOY_W-1:0]    joy;
        logic                vld;
        logic [RAW_W-1:0]    raw;
        for (i = 0; i < count; i++) begin
            // idle pattern changes every hundred ticks
            if (i % 100 == 0) begin
                tx_idle_on = ((i / 100) % 4) inside {0, 1} ? 1'b1 : 1'b0;
                rx_idle_on = ((i / 100) % 2) == 0;
            end
            if ($urandom_range(0, 19) == 0) begin
                // noise: any levels at all
                btn = $urandom;
                joy = $urandom;
            end else begin
                btn[BTN_RUN]   = ($urandom_range(0, 7) == 0);
                btn[BTN_LEVEL] = ($urandom_range(0, 5) == 0);
                btn[BTN_RESET] = ($urandom_range(0, 79) == 0);
                foreach (joy[j]) joy[j] = ($urandom_range(0, 3) == 0);
            end
            vld = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       raw = 16'd0;
                1:       raw = 16'hFFFF;
                2:       raw = SAMPLE_CEIL;
                3, 4:    raw = $urandom_range(0, 65535);
                default: raw = $urandom_range(0, 4095);
            endcase
            send_tick(btn, joy, vld, raw);
        end
    endtask

    // Main sequence
    initial begin
        mismatch_count = 0;
        checked_count  = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        clear_panel_model();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_sample_extremes();
        test_panel_controls();
        test_reset_press();
        test_backpressure();
        test_random_ticks(1000);

        s_axis_tvalid <= 1'b0;
        while (expected_panel_out.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/pmc_pkg.sv
rtl/pmc_div.sv
rtl/panel_monitor_controller_core.sv
rtl/pmc_checker.sv
verif/panel_monitor_controller_core_tb.sv
